// ----- rtl/core/tpim_pkg.sv -----
// Shared types and constants for the tensor permute index map.
// Holds field widths, opcodes and the controller-to-datapath command bundle.
// No dependencies.
package tpim_pkg;

	// Fixed field widths
	localparam int IDX_W     = 24;
	localparam int AXIS_W    = 3;
	localparam int CFG_W     = 4;
	localparam int DIV_STEPS = IDX_W;
	localparam int BIT_W     = $clog2(DIV_STEPS);

	// Input item opcodes
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MAP  = 1'b1
	} op_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;      // write one axis entry from the input fields
		logic start;     // capture out_index and is_last, clear the sum
		logic rd_en;     // read the axis entry at rd_addr
		logic div_init;  // seed the divider with the remaining index
		logic div_step;  // one restoring division step
		logic mul_en;    // register quotient times source stride
		logic acc_en;    // add product into sum, keep remainder
		logic out_load;  // move the sum into the output register
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic step_zero; // fetched axis step is zero
		logic out_busy;  // output register holds a result not taken this cycle
	} dp_sts_t;

endpackage

// ----- rtl/core/tpim_dpath.sv -----
// Datapath of the tensor permute index map: axis tables, restoring divider,
// multiplier, accumulator and output register.
// Depends on tpim_pkg; driven by commands from tpim_ctrl.
module tpim_dpath #(
	parameter int MAX_AXES   = 8,
	parameter int INDEX_BITS = 24,
	parameter int ADDR_W     = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tpim_pkg::dp_cmd_t                cmd,
	input  logic [ADDR_W-1:0]                rd_addr,
	input  logic [tpim_pkg::AXIS_W-1:0]      axis,
	input  logic [tpim_pkg::IDX_W-1:0]       out_step,
	input  logic [tpim_pkg::IDX_W-1:0]       source_stride,
	input  logic [tpim_pkg::IDX_W-1:0]       out_index,
	input  logic                             is_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tpim_pkg::IDX_W-1:0]       source_index,
	output logic                             last,
	output tpim_pkg::dp_sts_t                sts
);

	localparam int IDX_W = tpim_pkg::IDX_W;
	localparam int LIM_W = tpim_pkg::CFG_W + 1;
	localparam int OUT_W = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
	localparam logic [IDX_W-1:0] IDX_MASK = {IDX_W{1'b1}} >> (IDX_W - OUT_W);

	logic [IDX_W-1:0]   step_mem   [MAX_AXES];
	logic [IDX_W-1:0]   stride_mem [MAX_AXES];
	logic [IDX_W-1:0]   step_q;
	logic [IDX_W-1:0]   stride_q;
	logic [IDX_W-1:0]   remain_q;
	logic [IDX_W-1:0]   sum_q;
	logic               last_item_q;
	logic [IDX_W-1:0]   rem_q;
	logic [IDX_W-1:0]   quo_q;
	logic [IDX_W-1:0]   prod_q;
	logic [IDX_W:0]     trial;
	logic [IDX_W:0]     shifted;
	logic [2*IDX_W-1:0] prod_full;
	logic               wr_ok;
	logic               out_valid_q;
	logic [IDX_W-1:0]   source_index_q;
	logic               last_q;

	// Drop loads aimed past the table
	assign wr_ok = (LIM_W'(axis) < LIM_W'(MAX_AXES));

	// Write and read the axis tables
	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok) begin
			step_mem[ADDR_W'(axis)]   <= out_step;
			stride_mem[ADDR_W'(axis)] <= source_stride;
		end
		if (cmd.rd_en) begin
			step_q   <= step_mem[rd_addr];
			stride_q <= stride_mem[rd_addr];
		end
	end

	assign sts.step_zero = (step_q == '0);

	// Restoring division trial subtract
	assign shifted   = {rem_q, quo_q[IDX_W-1]};
	assign trial     = shifted - {1'b0, step_q};
	assign prod_full = quo_q * stride_q;

	// Divider, multiplier and accumulator
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			remain_q    <= out_index;
			sum_q       <= '0;
			last_item_q <= is_last;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			quo_q <= remain_q;
		end else if (cmd.div_step) begin
			if (!trial[IDX_W]) begin
				rem_q <= trial[IDX_W-1:0];
				quo_q <= {quo_q[IDX_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[IDX_W-1:0];
				quo_q <= {quo_q[IDX_W-2:0], 1'b0};
			end
		end
		if (cmd.mul_en) begin
			prod_q <= prod_full[IDX_W-1:0];
		end
		if (cmd.acc_en) begin
			sum_q    <= sum_q + prod_q;
			remain_q <= rem_q;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			source_index_q <= sum_q & IDX_MASK;
			last_q         <= last_item_q;
		end
	end

	// Output valid: set on load, clear on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_busy  = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign source_index  = source_index_q;
	assign last          = last_q;

endmodule

// ----- rtl/core/tpim_ctrl.sv -----
// Controller of the tensor permute index map: walks the axes of a map item
// and sequences the shared divider. Holds the axes_in_use register.
// Depends on tpim_pkg; commands tpim_dpath.
module tpim_ctrl #(
	parameter int MAX_AXES = 8,
	parameter int ADDR_W   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         opcode,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [tpim_pkg::CFG_W-1:0]   axes_in_use,
	output tpim_pkg::dp_cmd_t            cmd,
	output logic [ADDR_W-1:0]            rd_addr,
	input  tpim_pkg::dp_sts_t            sts
);

	localparam int CNT_W = $clog2(MAX_AXES + 1);
	localparam int LIM_W = tpim_pkg::CFG_W + 1;
	localparam int BIT_W = tpim_pkg::BIT_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_ACC   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [tpim_pkg::CFG_W-1:0] axes_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           cnt_d;
	logic [CNT_W-1:0]           limit_q;
	logic [BIT_W-1:0]           bit_q;
	logic [BIT_W-1:0]           bit_d;
	logic [LIM_W-1:0]           axes_sat;
	logic                       in_xfer;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign rd_addr   = cnt_q[ADDR_W-1:0];

	// Clamp the axis count to the table depth
	assign axes_sat = (LIM_W'(axes_q) > LIM_W'(MAX_AXES)) ? LIM_W'(MAX_AXES)
	                                                       : LIM_W'(axes_q);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		bit_d   = bit_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (opcode == tpim_pkg::OP_MAP) begin
						cmd.start = 1'b1;
						cnt_d     = '0;
						state_d   = S_FETCH;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_FETCH: begin
				if (cnt_q == limit_q) begin
					state_d = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.step_zero) begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_FETCH;
				end else begin
					cmd.div_init = 1'b1;
					bit_d        = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (bit_q == BIT_W'(tpim_pkg::DIV_STEPS - 1)) begin
					state_d = S_MUL;
				end else begin
					bit_d = bit_q + BIT_W'(1);
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = S_ACC;
			end
			S_ACC: begin
				cmd.acc_en = 1'b1;
				cnt_d      = cnt_q + CNT_W'(1);
				state_d    = S_FETCH;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, counters and the axis limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			limit_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			bit_q   <= bit_d;
			if (cmd.start) begin
				limit_q <= CNT_W'(axes_sat);
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axes_q <= tpim_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			axes_q <= axes_in_use;
		end
	end

	// Axis walk never passes the latched limit
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (cnt_q <= limit_q))
		else $error("axis counter passed limit");

	// Division step counter stays inside the quotient width
	a_bit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (bit_q < BIT_W'(tpim_pkg::DIV_STEPS)))
		else $error("divider step counter out of range");

	// A nonzero axis step always starts the divider at step zero
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !sts.step_zero) |=> (state_q == S_DIV && bit_q == '0))
		else $error("divider not started after nonzero step");

endmodule

// ----- rtl/core/tensor_permute_index_map_core.sv -----
// A load item writes one axis table entry. A map item walks n axes
// (n = min(axes_in_use, MAX_AXES)), one map item at a time, then raises out_valid.
// An axis with a nonzero step runs fetch, check, the shared 24-step restoring
// divider, multiply and accumulate; a zero step runs only fetch and check.
// The output register lets a new item be accepted while a result waits.
// Reset (arst_n low, asynchronous): idle, no result held, axes_in_use = 1.
module tensor_permute_index_map_core #(
	parameter int MAX_AXES   = 8,
	parameter int INDEX_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [tpim_pkg::AXIS_W-1:0]      axis,
	input  logic [tpim_pkg::IDX_W-1:0]       out_step,
	input  logic [tpim_pkg::IDX_W-1:0]       source_stride,
	input  logic [tpim_pkg::IDX_W-1:0]       out_index,
	input  logic                             is_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tpim_pkg::IDX_W-1:0]       source_index,
	output logic                             last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tpim_pkg::CFG_W-1:0]       axes_in_use
);

	localparam int ADDR_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

	tpim_pkg::dp_cmd_t  cmd;
	tpim_pkg::dp_sts_t  sts;
	logic [ADDR_W-1:0]  rd_addr;

	// Sequencer
	tpim_ctrl #(
		.MAX_AXES (MAX_AXES),
		.ADDR_W   (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.axes_in_use (axes_in_use),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.sts         (sts)
	);

	// Tables, divider, multiplier and output register
	tpim_dpath #(
		.MAX_AXES   (MAX_AXES),
		.INDEX_BITS (INDEX_BITS),
		.ADDR_W     (ADDR_W)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rd_addr       (rd_addr),
		.axis          (axis),
		.out_step      (out_step),
		.source_stride (source_stride),
		.out_index     (out_index),
		.is_last       (is_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.source_index  (source_index),
		.last          (last),
		.sts           (sts)
	);

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for tensor_permute_index_map_core: axis table loads, permuted
// index walks and axis-count settings, with random idling on both handshake sides.
// Depends on tpim_pkg and the core RTL.
module tb;

	localparam int MAX_AXES      = 8;
	localparam int INDEX_BITS    = 24;
	localparam int ITEM_TARGET   = 1950;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 300;
	localparam int RUN_LIMIT     = 4000000;
	localparam int REPORT_MAX    = 10;

	typedef logic [tpim_pkg::IDX_W-1:0]  idx_t;
	typedef logic [tpim_pkg::CFG_W-1:0]  axes_t;
	typedef logic [tpim_pkg::AXIS_W-1:0] axis_t;

	typedef struct packed {
		idx_t source_index;
		logic last;
	} source_pos_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	// Tracks the axis table and axis count, predicts each source position
	class permute_map_scoreboard;
		idx_t        step_tbl[MAX_AXES];
		idx_t        stride_tbl[MAX_AXES];
		axes_t       axes_cfg;
		source_pos_t expected_sources[$];
		int unsigned loads, maps, checked, errors;

		function new();
			axes_cfg = axes_t'(1);
			loads    = 0;
			maps     = 0;
			checked  = 0;
			errors   = 0;
			foreach (step_tbl[i]) begin
				step_tbl[i]   = '0;
				stride_tbl[i] = '0;
			end
		endfunction

		function void set_axes(axes_t value);
			axes_cfg = value;
		endfunction

		function int unsigned outstanding();
			return expected_sources.size();
		endfunction

		// Walk the axes in order: divide by the step, add quotient * stride, keep the
		// remainder. A zero step adds nothing; the sum wraps at the index width.
		function source_pos_t map_to_source(idx_t flat_out, logic is_last);
			idx_t                         remain;
			idx_t                         quot;
			idx_t                         sum;
			logic [2*tpim_pkg::IDX_W-1:0] prod;
			int                           walk;
			int                           j;
			source_pos_t                  res;
			walk   = (axes_cfg > MAX_AXES) ? MAX_AXES : int'(axes_cfg);
			remain = flat_out;
			sum    = '0;
			for (j = 0; j < walk; j++) begin
				if (step_tbl[j] != '0) begin
					quot   = remain / step_tbl[j];
					prod   = quot * stride_tbl[j];
					sum    = sum + prod[tpim_pkg::IDX_W-1:0];
					remain = remain % step_tbl[j];
				end
			end
			res.source_index = sum;
			res.last         = is_last;
			return res;
		endfunction

		function void note_input(tpim_pkg::op_t op, axis_t ax, idx_t step, idx_t stride,
				idx_t flat_out, logic is_last);
			if (op == tpim_pkg::OP_LOAD) begin
				step_tbl[ax]   = step;
				stride_tbl[ax] = stride;
				loads++;
			end else begin
				expected_sources.push_back(map_to_source(flat_out, is_last));
				maps++;
			end
		endfunction

		function void check_result(idx_t got_index, logic got_last);
			source_pos_t exp_pos;
			if (expected_sources.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("unexpected result: source_index %h last %b", got_index, got_last);
				return;
			end
			exp_pos = expected_sources.pop_front();
			checked++;
			if (got_index !== exp_pos.source_index || got_last !== exp_pos.last) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("mismatch on result %0d: source_index exp %h got %h, last exp %b got %b",
						checked, exp_pos.source_index, got_index, exp_pos.last, got_last);
			end
		endfunction
	endclass

	logic  clk           = 1'b0;
	logic  arst_n        = 1'b0;
	logic  in_valid      = 1'b0;
	logic  in_ready;
	logic  opcode        = 1'b0;
	axis_t axis          = '0;
	idx_t  out_step      = '0;
	idx_t  source_stride = '0;
	idx_t  out_index     = '0;
	logic  is_last       = 1'b0;
	logic  out_valid;
	logic  out_ready     = 1'b0;
	idx_t  source_index;
	logic  last;
	logic  cfg_valid     = 1'b0;
	logic  cfg_ready;
	axes_t axes_in_use   = '0;

	permute_map_scoreboard sb;
	int unsigned           cycle_count    = 0;
	int unsigned           items_sent     = 0;
	int unsigned           burst_left     = 0;
	logic [15:0]           settings_used  = '0;
	rx_mode_t              rx_mode        = RX_ALWAYS;
	int unsigned           rx_mode_timer  = 0;
	logic [3:0]            pattern_pos    = '0;
	localparam logic [15:0] STALL_PATTERN = 16'b1011_0011_1000_1111;

	tensor_permute_index_map_core #(
		.MAX_AXES  (MAX_AXES),
		.INDEX_BITS(INDEX_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.axis         (axis),
		.out_step     (out_step),
		.source_stride(source_stride),
		.out_index    (out_index),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.source_index (source_index),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.axes_in_use  (axes_in_use)
	);

	always #4 clk = ~clk;

	// Receiver: switch stall mode each time a random timer runs out
	always @(posedge clk) begin
		if (rx_mode_timer == 0) begin
			rx_mode       <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_timer <= $urandom_range(64, 512);
		end else begin
			rx_mode_timer <= rx_mode_timer - 1;
		end
		case (rx_mode)
			RX_ALWAYS: begin
				out_ready <= 1'b1;
			end
			RX_COIN: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				out_ready   <= STALL_PATTERN[pattern_pos];
				pattern_pos <= pattern_pos + 1'b1;
			end
		endcase
	end

	// Observe every transfer at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(source_index, last);
			if (in_valid && in_ready)
				sb.note_input(tpim_pkg::op_t'(opcode), axis, out_step, source_stride,
					out_index, is_last);
			if (cfg_valid && cfg_ready)
				sb.set_axes(axes_in_use);
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("** tensor_permute_index_map_core: FAILED **");
		$finish;
	end

	// Present one item, hold until accepted, then maybe drop valid for a gap
	task automatic send_item(tpim_pkg::op_t op, axis_t ax, idx_t step, idx_t stride,
			idx_t flat_out, logic lst);
		int gap;
		int roll;
		in_valid      <= 1'b1;
		opcode        <= op;
		axis          <= ax;
		out_step      <= step;
		source_stride <= stride;
		out_index     <= flat_out;
		is_last       <= lst;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			roll       = $urandom_range(0, 19);
			if (roll < 5)
				gap = 0;
			else if (roll < 15)
				gap = $urandom_range(1, 12);
			else if (roll < 19)
				gap = $urandom_range(13, 60);
			else
				gap = $urandom_range(61, 250);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold off until every expected result has come, then let trailing loads finish
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_axes(axes_t value);
		drain_results();
		cfg_valid   <= 1'b1;
		axes_in_use <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings_used[value] = 1'b1;
	endtask

	// Random load or map with fully random fields
	task automatic send_noise();
		axis_t ax;
		idx_t  step;
		ax   = axis_t'($urandom_range(0, MAX_AXES - 1));
		step = ($urandom_range(0, 7) == 0) ? idx_t'(0) : idx_t'($urandom());
		if ($urandom_range(0, 1) == 0)
			send_item(tpim_pkg::OP_LOAD, ax, step, idx_t'($urandom()), idx_t'($urandom()),
				1'($urandom()));
		else
			send_item(tpim_pkg::OP_MAP, ax, step, idx_t'($urandom()), idx_t'($urandom()),
				1'($urandom()));
	endtask

	// One permuted copy: load the table for random dims and order, then map a run
	task automatic send_transfer(int n);
		int unsigned dims[MAX_AXES];
		int unsigned src_dims[MAX_AXES];
		int unsigned steps[MAX_AXES];
		int unsigned src_strides[MAX_AXES];
		int          perm[MAX_AXES];
		int          load_order[MAX_AXES];
		int unsigned dim_max;
		int unsigned total;
		int unsigned start;
		int unsigned run_len;
		int unsigned flat;
		int          j;
		int          k;
		int          tmp;
		int          i;
		dim_max = (n <= 2) ? 4096 : ((n <= 4) ? 64 : 8);
		for (j = 0; j < n; j++) begin
			dims[j]       = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, dim_max);
			perm[j]       = j;
			load_order[j] = j;
		end
		// shuffle the permutation and the load order
		for (j = n - 1; j > 0; j--) begin
			k             = $urandom_range(0, j);
			tmp           = perm[j];
			perm[j]       = perm[k];
			perm[k]       = tmp;
			k             = $urandom_range(0, j);
			tmp           = load_order[j];
			load_order[j] = load_order[k];
			load_order[k] = tmp;
		end
		steps[n-1] = 1;
		for (j = n - 2; j >= 0; j--)
			steps[j] = steps[j+1] * dims[j+1];
		total = steps[0] * dims[0];
		for (j = 0; j < n; j++)
			src_dims[perm[j]] = dims[j];
		src_strides[n-1] = 1;
		for (j = n - 2; j >= 0; j--)
			src_strides[j] = src_strides[j+1] * src_dims[j+1];
		for (j = 0; j < n; j++) begin
			k = load_order[j];
			send_item(tpim_pkg::OP_LOAD, axis_t'(k), idx_t'(steps[k]),
				idx_t'(src_strides[perm[k]]), idx_t'($urandom()), 1'($urandom()));
		end
		// map consecutive output positions, mark the final one
		run_len = $urandom_range(1, 16);
		start   = $urandom_range(0, total - 1);
		for (i = 0; i < run_len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			flat = (start + i) % total;
			send_item(tpim_pkg::OP_MAP, axis_t'($urandom()), idx_t'($urandom()),
				idx_t'($urandom()), idx_t'(flat), i == run_len - 1);
		end
	endtask

	initial begin
		int    phase;
		int    roll;
		int    walked;
		int    t;
		int    n_transfers;
		axes_t setting;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fill the table with extreme entries, one zero step among them
		send_item(tpim_pkg::OP_LOAD, 3'd0, 24'hFFFFFF, 24'hFFFFFF, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd1, 24'h000001, 24'h000001, 24'hFFFFFF, 1'b1);
		send_item(tpim_pkg::OP_LOAD, 3'd2, 24'h000000, 24'hABCDEF, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd3, 24'h800000, 24'h000003, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd4, 24'h000010, 24'hFFFFFF, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd5, 24'h000003, 24'h000007, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd6, 24'h000001, 24'h555555, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd7, 24'h000002, 24'hAAAAAA, 24'h000000, 1'b0);
		// axis count still at its reset value
		send_item(tpim_pkg::OP_MAP, 3'd7, 24'h000000, 24'h000000, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
		// all axes walked
		write_axes(axes_t'(MAX_AXES));
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b0);
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'h123456, 1'b0);
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'h000000, 1'b1);
		// zero axes gives source position zero
		write_axes(axes_t'(0));
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1);
		// counts above the table size saturate
		write_axes(axes_t'(15));
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1);
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'h7FFFFF, 1'b0);
		write_axes(axes_t'(9));
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'hABCDEF, 1'b0);
		send_item(tpim_pkg::OP_LOAD, 3'd0, 24'h000000, 24'h000000, 24'h000000, 1'b0);
		send_item(tpim_pkg::OP_MAP, 3'd0, 24'h000000, 24'h000000, 24'hABCDEF, 1'b1);

		// Random phases: new axis count, then permuted transfers with some noise
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			roll = $urandom_range(0, 9);
			if (roll == 0)
				setting = axes_t'(0);
			else if (roll == 1)
				setting = axes_t'($urandom_range(MAX_AXES + 1, 15));
			else if (roll == 2)
				setting = axes_t'(MAX_AXES);
			else
				setting = axes_t'($urandom_range(1, MAX_AXES));
			write_axes(setting);
			walked      = (setting > MAX_AXES) ? MAX_AXES : int'(setting);
			n_transfers = $urandom_range(2, 5);
			for (t = 0; t < n_transfers; t++) begin
				if (walked == 0)
					repeat (12) send_noise();
				else
					send_transfer(walked);
				// hold the sender once mid-phase until the pipe is empty
				if (phase == 3 && t == 0)
					drain_results();
			end
			phase++;
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		$display("Covered %0d table loads and %0d index maps over %0d phases, %0d results checked.",
			sb.loads, sb.maps, phase, sb.checked);
		$display("Axis counts exercised: %0d of 16 settings, %0d errors.",
			$countones(settings_used), sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("** tensor_permute_index_map_core: PASSED **");
		else
			$display("** tensor_permute_index_map_core: FAILED **");
		$finish;
	end

endmodule
